@@ hdl/dual_motor_pi_speed_control_macros.svh @@
// Assertion macros for the dual-motor PI speed controller.
// Used by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef DUAL_MOTOR_PI_SPEED_CONTROL_MACROS_SVH
`define DUAL_MOTOR_PI_SPEED_CONTROL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMPSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DMPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dmpsc_pkg.sv @@
// Package for the dual-motor PI speed controller: widths, constants, codes and types.
// Used by the channel interfaces and the top level; depends on nothing else.
`timescale 1ns / 1ps

package dmpsc_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned TICK_BITS_DEF     = 10;
  localparam int unsigned INTEGRAL_BITS_DEF = 32;

  // Fixed field widths.
  localparam int unsigned ECHO_W  = 14;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned PWM_W   = 8;
  localparam int unsigned KP_W    = 17;
  localparam int unsigned KI_W    = 17;
  localparam int unsigned TGT_W   = 18;

  // Second operand of the shared multiplier (signed).
  localparam int unsigned MUL_B_W = 18;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_TARGET = 2'd2;

  localparam logic [KP_W-1:0]  PROP_GAIN_RST     = 17'd3745;
  localparam logic [KI_W-1:0]  INTEGRAL_GAIN_RST = 17'd29789;
  localparam logic [TGT_W-1:0] CRUISE_TARGET_RST = 18'd131072;

  // Distance is echo * 0.17 mm, so "distance below D mm" is echo < ceil(D * 100 / 17).
  localparam int unsigned EchoScale = 17;
  localparam logic [ECHO_W-1:0] ECHO_LIM_STOP = ECHO_W'((10000 + EchoScale - 1) / EchoScale);
  localparam logic [ECHO_W-1:0] ECHO_LIM_L4   = ECHO_W'((20000 + EchoScale - 1) / EchoScale);
  localparam logic [ECHO_W-1:0] ECHO_LIM_L3   = ECHO_W'((30000 + EchoScale - 1) / EchoScale);
  localparam logic [ECHO_W-1:0] ECHO_LIM_L2   = ECHO_W'((40000 + EchoScale - 1) / EchoScale);
  localparam logic [ECHO_W-1:0] ECHO_LIM_L1   = ECHO_W'((50000 + EchoScale - 1) / EchoScale);

  // Speed targets in rev/s, unsigned Q2.16.
  localparam logic [TGT_W-1:0] TGT_L1   = 18'd124518;
  localparam logic [TGT_W-1:0] TGT_L2   = 18'd121242;
  localparam logic [TGT_W-1:0] TGT_L3   = 18'd114688;
  localparam logic [TGT_W-1:0] TGT_L4   = 18'd111411;
  localparam logic [TGT_W-1:0] TGT_STOP = 18'd0;

  // Target level codes on the result channel.
  localparam logic [LEVEL_W-1:0] LVL_CRUISE = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_1      = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_2      = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_3      = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_4      = 3'd4;
  localparam logic [LEVEL_W-1:0] LVL_STOP   = 3'd5;

  // speed_q16 = floor(ticks * SpeedNum / SpeedDiv). SpeedNum leaves a remainder of one,
  // so the quotient splits into ticks * SPEED_INT plus floor(ticks / SpeedDiv).
  localparam int unsigned SpeedNum  = 327680;
  localparam int unsigned SpeedDiv  = 11;
  localparam int unsigned SPEED_INT = SpeedNum / SpeedDiv;

  // Command scaling to PWM: floor(cmd * 51 / 2^32), with a clamp from 2^40 upwards.
  localparam int unsigned PWM_GAIN       = 51;
  localparam int unsigned PWM_SHIFT      = 32;
  localparam int unsigned CMD_CLAMP_BIT  = 40;
  localparam logic [PWM_W-1:0] PWM_MAX   = '1;
  localparam logic [PWM_W-1:0] PWM_ZERO  = '0;

  // Sequencer states; each motor goes through SPD_INT to PWM in turn.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPD_INT,
    ST_SPD_FRAC,
    ST_ERR,
    ST_INTEG,
    ST_ITERM,
    ST_CMD,
    ST_SCALE,
    ST_PWM,
    ST_DONE
  } dmpsc_state_e;

  // Operand selects of the shared multiplier.
  typedef enum logic [1:0] {
    MA_TICKS,
    MA_ERR,
    MA_INTEG,
    MA_CMD
  } mul_a_sel_e;

  typedef enum logic [2:0] {
    MB_SPEED_INT,
    MB_RECIP,
    MB_KP,
    MB_KI,
    MB_PWM_GAIN
  } mul_b_sel_e;

  // Accumulator update.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_PROD,
    ACC_SUM
  } acc_op_e;

  // Datapath controls driven by the sequencer.
  typedef struct packed {
    mul_a_sel_e a_sel;
    mul_b_sel_e b_sel;
    logic       prod_en;
    acc_op_e    acc_op;
    logic       err_en;
    logic       integ_en;
    logic       pwm_en;
    logic       out_load;
    logic       in_ready;
  } dmpsc_ctrl_t;

endpackage

@@ hdl/dmpsc_in_if.sv @@
// Input channel of the dual-motor PI speed controller: valid/ready and one tick's samples.
// Depends on dmpsc_pkg for field widths.
`timescale 1ns / 1ps

interface dmpsc_in_if
  import dmpsc_pkg::*;
#(
  parameter int unsigned TICK_BITS = TICK_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TICK_BITS-1:0] ticks_motor_one;
  logic [TICK_BITS-1:0] ticks_motor_two;
  logic [ECHO_W-1:0]    echo_front_us;
  logic [ECHO_W-1:0]    echo_side_us;

  modport source (
    output valid, ticks_motor_one, ticks_motor_two, echo_front_us, echo_side_us,
    input  ready
  );

  modport sink (
    input  valid, ticks_motor_one, ticks_motor_two, echo_front_us, echo_side_us,
    output ready
  );
endinterface

@@ hdl/dmpsc_out_if.sv @@
// Result channel of the dual-motor PI speed controller: valid/ready, PWM duties and level.
// Depends on dmpsc_pkg for field widths.
`timescale 1ns / 1ps

interface dmpsc_out_if
  import dmpsc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [PWM_W-1:0]   pwm_motor_one;
  logic [PWM_W-1:0]   pwm_motor_two;
  logic [LEVEL_W-1:0] target_level;

  modport source (
    output valid, pwm_motor_one, pwm_motor_two, target_level,
    input  ready
  );

  modport sink (
    input  valid, pwm_motor_one, pwm_motor_two, target_level,
    output ready
  );
endinterface

@@ hdl/dual_motor_pi_speed_control.sv @@
// Top level of the dual-motor PI speed controller: sequencer, shared multiplier, APB registers.
// Depends on dmpsc_pkg, dmpsc_in_if, dmpsc_out_if and dual_motor_pi_speed_control_macros.svh.
//
// Usage: one transfer on in_i per control tick carries both encoder counts and both echo
// widths. The block picks a speed target from the nearer echo, runs one PI loop per motor
// and returns one transfer on out_o with both PWM duties and the target level.
// The sequencer returns to idle after each item, so a new item is taken only once the last
// one is finished. Both motors go through one shared signed multiplier, eight sequencer
// steps per motor (two for the speed estimate, then error, P product with the integrator
// update, I product, sum, PWM scaling and clamp), then one step to load the result.
// in_i.ready is high only while the sequencer is idle. The result sits in an output
// register, so a new item is taken while out_o waits; if the receiver still stalls when the
// next result is ready, the sequencer holds it until out_o is free.
// Reset (rst_ni low, asynchronous) clears both integrators, restores the default gains and
// cruise target, and empties the output register. Configuration is an APB-style port with
// registers at byte addresses 0, 4 and 8; pready is always high and writes take effect at
// the access cycle.
`timescale 1ns / 1ps
`include "dual_motor_pi_speed_control_macros.svh"

module dual_motor_pi_speed_control
  import dmpsc_pkg::*;
#(
  parameter int unsigned TICK_BITS     = TICK_BITS_DEF,
  parameter int unsigned INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dmpsc_in_if.sink              in_i,
  dmpsc_out_if.source           out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Derived widths. floor(t / 11) is exact as (t * RECIP_MUL) >> RECIP_SHIFT for any
  // TICK_BITS-wide t, since the rounding error of RECIP_MUL is below 16.
  localparam int unsigned RECIP_SHIFT = TICK_BITS + 4;
  localparam longint unsigned RecipMul =
    ((64'd1 << RECIP_SHIFT) + SpeedDiv - 1) / SpeedDiv;
  localparam int unsigned ERR_W   = TICK_BITS + 16;
  localparam int unsigned MUL_A_W =
    (INTEGRAL_BITS > CMD_CLAMP_BIT + 1) ? INTEGRAL_BITS : CMD_CLAMP_BIT + 1;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned SUM_W   = ((INTEGRAL_BITS > ERR_W) ? INTEGRAL_BITS : ERR_W) + 1;

  localparam logic signed [INTEGRAL_BITS-1:0] INT_MAX = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
  localparam logic signed [INTEGRAL_BITS-1:0] INT_MIN = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};

  localparam logic [MUL_B_W-1:0] B_SPEED_INT = MUL_B_W'(SPEED_INT);
  localparam logic [MUL_B_W-1:0] B_RECIP     = MUL_B_W'(RecipMul);
  localparam logic [MUL_B_W-1:0] B_PWM_GAIN  = MUL_B_W'(PWM_GAIN);

  // Configuration registers.
  logic [KP_W-1:0]  kp_q;
  logic [KI_W-1:0]  ki_q;
  logic [TGT_W-1:0] cruise_q;

  // Sequencer.
  dmpsc_state_e state_q, state_d;
  logic         motor_q, motor_d;
  dmpsc_ctrl_t  ctrl;

  // Per-item operands.
  logic [TICK_BITS-1:0] ticks_one_q, ticks_two_q, ticks_cur;
  logic [TGT_W-1:0]     target_q, target_in;
  logic [LEVEL_W-1:0]   level_q, level_in;
  logic [ECHO_W-1:0]    echo_near;

  // Datapath.
  logic signed [INTEGRAL_BITS-1:0] integ_one_q, integ_two_q, integ_cur, integ_sat;
  logic signed [SUM_W-1:0]         integ_sum;
  logic signed [ERR_W-1:0]         err_q, err_next;
  logic signed [MUL_A_W-1:0]       mul_a;
  logic signed [MUL_B_W-1:0]       mul_b;
  logic signed [MUL_P_W-1:0]       mul_p, prod_q, acc_q, speed, tgt_ext;
  logic [PWM_W-1:0]                pwm_val, pwm_one_q, pwm_two_q;
  logic                            cmd_le0, cmd_big, scale_over;

  // Result register.
  logic               out_valid_q;
  logic [PWM_W-1:0]   out_pwm_one_q, out_pwm_two_q;
  logic [LEVEL_W-1:0] out_level_q;

  // Configuration port: writes at the access cycle, reads return the register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= PROP_GAIN_RST;
      ki_q     <= INTEGRAL_GAIN_RST;
      cruise_q <= CRUISE_TARGET_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[CFG_ADDR_W-1:2])
        REG_PROP_GAIN:     kp_q     <= pwdata[KP_W-1:0];
        REG_INTEGRAL_GAIN: ki_q     <= pwdata[KI_W-1:0];
        REG_CRUISE_TARGET: cruise_q <= pwdata[TGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_ADDR_W-1:2])
      REG_PROP_GAIN:     prdata = CFG_DATA_W'(kp_q);
      REG_INTEGRAL_GAIN: prdata = CFG_DATA_W'(ki_q);
      REG_CRUISE_TARGET: prdata = CFG_DATA_W'(cruise_q);
      default:           prdata = '0;
    endcase
  end

  // Speed target from the nearer echo.
  assign echo_near = (in_i.echo_front_us < in_i.echo_side_us) ?
                     in_i.echo_front_us : in_i.echo_side_us;

  always_comb begin
    if (echo_near < ECHO_LIM_STOP) begin
      level_in  = LVL_STOP;
      target_in = TGT_STOP;
    end else if (echo_near < ECHO_LIM_L4) begin
      level_in  = LVL_4;
      target_in = TGT_L4;
    end else if (echo_near < ECHO_LIM_L3) begin
      level_in  = LVL_3;
      target_in = TGT_L3;
    end else if (echo_near < ECHO_LIM_L2) begin
      level_in  = LVL_2;
      target_in = TGT_L2;
    end else if (echo_near < ECHO_LIM_L1) begin
      level_in  = LVL_1;
      target_in = TGT_L1;
    end else begin
      level_in  = LVL_CRUISE;
      target_in = cruise_q;
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    motor_d = motor_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_SPD_INT;
          motor_d = 1'b0;
        end
      end
      ST_SPD_INT:  state_d = ST_SPD_FRAC;
      ST_SPD_FRAC: state_d = ST_ERR;
      ST_ERR:      state_d = ST_INTEG;
      ST_INTEG:    state_d = ST_ITERM;
      ST_ITERM:    state_d = ST_CMD;
      ST_CMD:      state_d = ST_SCALE;
      ST_SCALE:    state_d = ST_PWM;
      ST_PWM: begin
        if (motor_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SPD_INT;
          motor_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: datapath controls.
  always_comb begin
    ctrl          = '0;
    ctrl.a_sel    = MA_TICKS;
    ctrl.b_sel    = MB_SPEED_INT;
    ctrl.acc_op   = ACC_HOLD;
    case (state_q)
      ST_IDLE: ctrl.in_ready = 1'b1;
      ST_SPD_INT: begin
        ctrl.prod_en = 1'b1;
      end
      ST_SPD_FRAC: begin
        ctrl.b_sel   = MB_RECIP;
        ctrl.prod_en = 1'b1;
        ctrl.acc_op  = ACC_PROD;
      end
      ST_ERR: ctrl.err_en = 1'b1;
      ST_INTEG: begin
        ctrl.a_sel    = MA_ERR;
        ctrl.b_sel    = MB_KP;
        ctrl.prod_en  = 1'b1;
        ctrl.integ_en = 1'b1;
      end
      ST_ITERM: begin
        ctrl.a_sel   = MA_INTEG;
        ctrl.b_sel   = MB_KI;
        ctrl.prod_en = 1'b1;
        ctrl.acc_op  = ACC_PROD;
      end
      ST_CMD: ctrl.acc_op = ACC_SUM;
      ST_SCALE: begin
        ctrl.a_sel   = MA_CMD;
        ctrl.b_sel   = MB_PWM_GAIN;
        ctrl.prod_en = 1'b1;
      end
      ST_PWM:  ctrl.pwm_en   = 1'b1;
      ST_DONE: ctrl.out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      motor_q <= 1'b0;
    end else begin
      state_q <= state_d;
      motor_q <= motor_d;
    end
  end

  assign in_i.ready = ctrl.in_ready;

  // Operands of the item in flight.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && ctrl.in_ready) begin
      ticks_one_q <= in_i.ticks_motor_one;
      ticks_two_q <= in_i.ticks_motor_two;
      target_q    <= target_in;
      level_q     <= level_in;
    end
  end

  assign ticks_cur = motor_q ? ticks_two_q : ticks_one_q;
  assign integ_cur = motor_q ? integ_two_q : integ_one_q;

  // Shared multiplier operand selection.
  always_comb begin
    case (ctrl.a_sel)
      MA_TICKS: mul_a = $signed({{(MUL_A_W-TICK_BITS){1'b0}}, ticks_cur});
      MA_ERR:   mul_a = MUL_A_W'(err_q);
      MA_INTEG: mul_a = MUL_A_W'(integ_cur);
      MA_CMD:   mul_a = $signed({{(MUL_A_W-CMD_CLAMP_BIT){1'b0}},
                                 acc_q[CMD_CLAMP_BIT-1:0]});
      default:  mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      MB_SPEED_INT: mul_b = $signed(B_SPEED_INT);
      MB_RECIP:     mul_b = $signed(B_RECIP);
      MB_KP:        mul_b = $signed({{(MUL_B_W-KP_W){1'b0}}, kp_q});
      MB_KI:        mul_b = $signed({{(MUL_B_W-KI_W){1'b0}}, ki_q});
      MB_PWM_GAIN:  mul_b = $signed(B_PWM_GAIN);
      default:      mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Speed estimate and error: speed = ticks * SPEED_INT + floor(ticks / 11).
  assign speed    = acc_q + (prod_q >>> RECIP_SHIFT);
  assign tgt_ext  = $signed({{(MUL_P_W-TGT_W){1'b0}}, target_q});
  assign err_next = ERR_W'(tgt_ext - speed);

  // Saturating integrator update.
  assign integ_sum = SUM_W'(integ_cur) + SUM_W'(err_q);

  always_comb begin
    if (integ_sum > SUM_W'(INT_MAX)) begin
      integ_sat = INT_MAX;
    end else if (integ_sum < SUM_W'(INT_MIN)) begin
      integ_sat = INT_MIN;
    end else begin
      integ_sat = INTEGRAL_BITS'(integ_sum);
    end
  end

  // PWM from the command held in acc_q and its scaled value in prod_q.
  assign cmd_le0    = acc_q[MUL_P_W-1] || (acc_q == '0);
  assign cmd_big    = |acc_q[MUL_P_W-2:CMD_CLAMP_BIT];
  assign scale_over = |prod_q[MUL_P_W-1:PWM_SHIFT+PWM_W];

  always_comb begin
    if (cmd_le0) begin
      pwm_val = PWM_ZERO;
    end else if (cmd_big || scale_over) begin
      pwm_val = PWM_MAX;
    end else begin
      pwm_val = prod_q[PWM_SHIFT+PWM_W-1:PWM_SHIFT];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (ctrl.prod_en) begin
      prod_q <= mul_p;
    end
    case (ctrl.acc_op)
      ACC_PROD: acc_q <= prod_q;
      ACC_SUM:  acc_q <= acc_q + prod_q;
      default:  ;
    endcase
    if (ctrl.err_en) begin
      err_q <= err_next;
    end
    if (ctrl.pwm_en) begin
      if (motor_q) begin
        pwm_two_q <= pwm_val;
      end else begin
        pwm_one_q <= pwm_val;
      end
    end
  end

  // Integrators, one per motor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_one_q <= '0;
      integ_two_q <= '0;
    end else if (ctrl.integ_en) begin
      if (motor_q) begin
        integ_two_q <= integ_sat;
      end else begin
        integ_one_q <= integ_sat;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_pwm_one_q <= pwm_one_q;
      out_pwm_two_q <= pwm_two_q;
      out_level_q   <= level_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pwm_motor_one = out_pwm_one_q;
  assign out_o.pwm_motor_two = out_pwm_two_q;
  assign out_o.target_level  = out_level_q;

  // An accepted item always starts with the speed estimate of motor one.
  `DMPSC_ASSERT_NEXT(a_start_motor_one, clk_i, rst_ni, in_i.valid && in_i.ready,
                     state_q == ST_SPD_INT && !motor_q, "item did not start on motor one")

  // A result only appears after the sequencer has finished both motors.
  `DMPSC_ASSERT_NOW(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q),
                    $past(state_q) == ST_DONE, "result loaded outside the final step")

  // The motor select only moves at the end of a motor or when an item is taken.
  `DMPSC_ASSERT_NOW(a_motor_switch, clk_i, rst_ni, motor_q != $past(motor_q),
                    $past(state_q) == ST_PWM || $past(state_q) == ST_IDLE,
                    "motor select changed in the middle of a motor")

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the dual-motor PI speed controller.
// Holds its own speed-target and PI duty predictor and checks every result transfer.
// Depends on dmpsc_pkg, dmpsc_in_if, dmpsc_out_if and dual_motor_pi_speed_control.
`timescale 1ns / 1ps

module tb_top
  import dmpsc_pkg::*;
;

  localparam int unsigned CLK_PERIOD       = 8;
  localparam int unsigned RESET_CYCLES     = 6;
  localparam int unsigned WATCHDOG_LIMIT   = 3000;
  localparam int unsigned END_WAIT         = 40;
  localparam int unsigned LONG_HOLD_AT     = 400;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned TICK_W           = TICK_BITS_DEF;
  localparam int unsigned INTEG_W          = INTEGRAL_BITS_DEF;

  // Register index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Encoder pulses to rev/s in Q16.16: ticks * 65536 / 2.2.
  localparam longint SPEED_MUL = 327680;
  localparam longint SPEED_DIV = 11;
  // Echo microseconds to hundredths of a millimetre.
  localparam int unsigned ECHO_TO_MM100 = 17;
  // Smallest echo that is no longer closer than 100, 200, 300, 400 and 500 mm.
  localparam int unsigned ECHO_EDGE [5] = '{589, 1177, 1765, 2353, 2942};

  typedef struct packed {
    logic [TICK_W-1:0] ticks_one;
    logic [TICK_W-1:0] ticks_two;
    logic [ECHO_W-1:0] echo_front;
    logic [ECHO_W-1:0] echo_side;
  } tick_t;

  typedef struct packed {
    logic [PWM_W-1:0]   pwm_one;
    logic [PWM_W-1:0]   pwm_two;
    logic [LEVEL_W-1:0] level;
  } duty_t;

  // Predicts the duties and target level of each tick and checks the results in order.
  class duty_scoreboard;
    logic [KP_W-1:0]  kp;
    logic [KI_W-1:0]  ki;
    logic [TGT_W-1:0] cruise;
    longint           integ_one;
    longint           integ_two;
    duty_t            expected_duties[$];
    duty_t            last_duty;
    int unsigned      errors;

    function new();
      kp        = 17'd3745;
      ki        = 17'd29789;
      cruise    = 18'd131072;
      integ_one = 0;
      integ_two = 0;
      last_duty = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PROP_GAIN:     kp = value[KP_W-1:0];
        REG_INTEGRAL_GAIN: ki = value[KI_W-1:0];
        REG_CRUISE_TARGET: cruise = value[TGT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_duties.size();
    endfunction

    function longint clamp_integral(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (INTEG_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // One PI loop: integrate the error, form kp*err + ki*integral in Q32, scale to PWM.
    function logic [PWM_W-1:0] motor_duty(logic [TICK_W-1:0] ticks, longint target,
                                          inout longint integ);
      longint           speed;
      longint           err;
      longint           i_term;
      longint           cmd;
      longint unsigned  mag;
      longint unsigned  cap;
      speed = (longint'(ticks) * SPEED_MUL) / SPEED_DIV;
      err   = target - speed;
      integ = clamp_integral(integ + err);
      cap   = 64'd1 << 62;
      mag   = (integ < 0) ? -integ : integ;
      if (ki != 0 && mag > cap / ki) mag = cap;
      else mag = mag * ki;
      i_term = (integ < 0) ? -longint'(mag) : longint'(mag);
      cmd    = longint'(kp) * err + i_term;
      if (cmd <= 0) return '0;
      if (cmd >= (longint'(1) <<< 40)) return '1;
      mag = cmd;
      mag = (mag * 51) >> 32;
      return (mag > 255) ? 8'd255 : mag[PWM_W-1:0];
    endfunction

    function void note_input(tick_t t);
      duty_t       d;
      int unsigned closest;
      longint      target;
      closest = ECHO_TO_MM100 * ((t.echo_front < t.echo_side) ? t.echo_front : t.echo_side);
      if (closest < 10000) begin
        d.level = LVL_STOP;
        target  = 0;
      end else if (closest < 20000) begin
        d.level = LVL_4;
        target  = 111411;
      end else if (closest < 30000) begin
        d.level = LVL_3;
        target  = 114688;
      end else if (closest < 40000) begin
        d.level = LVL_2;
        target  = 121242;
      end else if (closest < 50000) begin
        d.level = LVL_1;
        target  = 124518;
      end else begin
        d.level = LVL_CRUISE;
        target  = longint'(cruise);
      end
      d.pwm_one = motor_duty(t.ticks_one, target, integ_one);
      d.pwm_two = motor_duty(t.ticks_two, target, integ_two);
      expected_duties.push_back(d);
      last_duty = d;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(duty_t got);
      duty_t want;
      if (expected_duties.size() == 0) begin
        report($sformatf("result %0d/%0d/%0d with nothing expected",
                         got.pwm_one, got.pwm_two, got.level));
        return;
      end
      want = expected_duties.pop_front();
      if (got.pwm_one !== want.pwm_one)
        report($sformatf("pwm_motor_one %0d, expected %0d", got.pwm_one, want.pwm_one));
      if (got.pwm_two !== want.pwm_two)
        report($sformatf("pwm_motor_two %0d, expected %0d", got.pwm_two, want.pwm_two));
      if (got.level !== want.level)
        report($sformatf("target_level %0d, expected %0d", got.level, want.level));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  duty_scoreboard sb;
  bit             steady;
  bit             long_hold_done;
  int unsigned    results_seen;
  int unsigned    idle_cycles;

  dmpsc_in_if #(.TICK_BITS(TICK_W)) in_if ();
  dmpsc_out_if out_if ();

  dual_motor_pi_speed_control #(
    .TICK_BITS     (TICK_W),
    .INTEGRAL_BITS (INTEG_W)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic tick_t make_tick(int unsigned t1, int unsigned t2,
                                      int unsigned ef, int unsigned es);
    tick_t t;
    t.ticks_one  = TICK_W'(t1);
    t.ticks_two  = TICK_W'(t2);
    t.echo_front = ECHO_W'(ef);
    t.echo_side  = ECHO_W'(es);
    return t;
  endfunction

  // Most counts follow a crude motor that runs at a speed proportional to its last duty,
  // which keeps the loop near balance; the rest are slow or arbitrary.
  function automatic logic [TICK_W-1:0] pick_ticks(logic [PWM_W-1:0] duty);
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      v = int'(duty) / 20 + int'($urandom_range(0, 4)) - 2;
      return (v < 0) ? '0 : TICK_W'(v);
    end
    if (r < 85) return TICK_W'($urandom_range(0, 31));
    return TICK_W'($urandom_range(0, (1 << TICK_W) - 1));
  endfunction

  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned r;
    t.ticks_one = pick_ticks(sb.last_duty.pwm_one);
    t.ticks_two = pick_ticks(sb.last_duty.pwm_two);
    r = $urandom_range(0, 99);
    if (r < 50) t.echo_front = ECHO_W'($urandom_range(ECHO_EDGE[4], 10000));
    else if (r < 75)
      t.echo_front = ECHO_W'(ECHO_EDGE[$urandom_range(0, 4)] + $urandom_range(0, 6) - 3);
    else if (r < 90) t.echo_front = ECHO_W'($urandom_range(0, 10000));
    else t.echo_front = ECHO_W'($urandom_range(0, (1 << ECHO_W) - 1));
    r = $urandom_range(0, 99);
    if (r < 70) t.echo_side = ECHO_W'($urandom_range(ECHO_EDGE[4], (1 << ECHO_W) - 1));
    else t.echo_side = ECHO_W'($urandom_range(0, (1 << ECHO_W) - 1));
    return t;
  endfunction

  // One input transfer; valid stays high into the next item when no gap is drawn.
  task automatic send_tick(tick_t t);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.ticks_motor_one <= t.ticks_one;
    in_if.ticks_motor_two <= t.ticks_two;
    in_if.echo_front_us   <= t.echo_front;
    in_if.echo_side_us    <= t.echo_side;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(t);
  endtask

  task automatic feed(int unsigned n);
    repeat (n) send_tick(random_tick());
  endtask

  // Stop offering and wait until every expected result has been transferred.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // APB write: setup then access; a following write starts its setup straight away.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
  endtask

  task automatic end_cfg();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random stalls, and once a long hold so that the block backs up.
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = steady ? 0 : pick_gap();
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        stall          = LONG_HOLD_CYCLES;
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Result monitor and watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    duty_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.pwm_one = out_if.pwm_motor_one;
        got.pwm_two = out_if.pwm_motor_two;
        got.level   = out_if.target_level;
        sb.check_result(got);
        results_seen++;
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed ticks, then random phases under several settings.
  initial begin
    sb                     = new();
    steady                 = 1'b0;
    long_hold_done         = 1'b0;
    results_seen           = 0;
    idle_cycles            = 0;
    rst_ni                <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    in_if.valid           <= 1'b0;
    in_if.ticks_motor_one <= '0;
    in_if.ticks_motor_two <= '0;
    in_if.echo_front_us   <= '0;
    in_if.echo_side_us    <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Echo timeouts, field extremes, echoes beyond range and alternating bit patterns.
    send_tick(make_tick(0, 0, 0, 0));
    send_tick(make_tick(1023, 1023, 10000, 10000));
    send_tick(make_tick(0, 0, 16383, 16383));
    send_tick(make_tick(10'h155, 10'h2AA, 14'h2AAA, 14'h1555));
    // Just below every distance threshold from the front sensor, and at it from the side sensor.
    for (int i = 0; i < 5; i++) begin
      send_tick(make_tick(6, 3, ECHO_EDGE[i] - 1, 10000));
      send_tick(make_tick(3, 6, 10000, ECHO_EDGE[i]));
    end
    send_tick(make_tick(5, 4, 10000, 0));
    send_tick(make_tick(1023, 0, 3000, 2000));
    send_tick(make_tick(0, 1023, 16383, 2942));
    // Stalled motors at cruise wind the integrators up towards full duty.
    repeat (4) send_tick(make_tick(0, 0, 9000, 9000));

    // Default gains, with a pause in the middle until the block has drained.
    feed(120);
    settle();
    feed(130);
    settle();

    // All gains and the cruise target at zero, with no idling on either side.
    write_reg(REG_PROP_GAIN, '0);
    write_reg(REG_INTEGRAL_GAIN, '0);
    write_reg(REG_CRUISE_TARGET, '0);
    end_cfg();
    steady = 1'b1;
    feed(100);
    settle();
    steady = 1'b0;

    // Everything at full scale; the spare index must be ignored.
    write_reg(REG_PROP_GAIN, '1);
    write_reg(REG_INTEGRAL_GAIN, 32'd131071);
    write_reg(REG_CRUISE_TARGET, 32'd262143);
    write_reg(REG_SPARE, '1);
    end_cfg();
    // Fast motors told to stop drive both integrators into negative saturation.
    repeat (80) send_tick(make_tick(1023, 1023, 0, 0));
    feed(170);
    settle();

    // Random settings, the last phase back at the reset values.
    for (int p = 0; p < 5; p++) begin
      if (p == 4) begin
        write_reg(REG_PROP_GAIN, 32'(PROP_GAIN_RST));
        write_reg(REG_INTEGRAL_GAIN, 32'(INTEGRAL_GAIN_RST));
        write_reg(REG_CRUISE_TARGET, 32'(CRUISE_TARGET_RST));
      end else begin
        write_reg(REG_PROP_GAIN, $urandom_range(0, 1) ? $urandom_range(0, 8000) : $urandom());
        write_reg(REG_INTEGRAL_GAIN,
                  $urandom_range(0, 1) ? $urandom_range(0, 40000) : $urandom());
        write_reg(REG_CRUISE_TARGET,
                  $urandom_range(0, 3) != 0 ? $urandom_range(60000, 200000) : $urandom());
      end
      end_cfg();
      steady = (p == 1);
      feed(105);
      settle();
    end
    steady = 1'b0;

    repeat (END_WAIT) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
